// ----- sv/btpd_pkg.sv -----
// Package for the button triple-press detector.
// Holds the register map, reset values and the structs shared by the core and the top level.
// No dependencies.
package btpd_pkg;

    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int DEBOUNCE_W   = 10;
    localparam int WINDOW_W     = 16;
    localparam int GAP_W        = 16;
    localparam int SINCE_W      = 16;
    localparam int TOTAL_W      = 32;
    localparam int TALLY_W      = 3;
    localparam int PENDING_W    = 2;
    localparam int PRESSES_DEFAULT = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP  = 2'd3;

    localparam logic                  ENABLE_RST   = 1'b1;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd50;
    localparam logic [WINDOW_W-1:0]   WINDOW_RST   = 16'd2000;
    localparam logic [GAP_W-1:0]      MIN_GAP_RST  = 16'd150;

    typedef struct packed {
        logic                  enable;
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic [WINDOW_W-1:0]   window_ticks;
        logic [GAP_W-1:0]      min_gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic                 triple_detected;
        logic                 press_accepted;
        logic [PENDING_W-1:0] pending_presses;
        logic [TOTAL_W-1:0]   total_presses;
    } t_result;

endpackage

// ----- sv/btpd_core.sv -----
// Tick-by-tick state of the detector: debounce, window, gap and lifetime counters.
// Computes the result of one tick from the registered state and updates it on a step.
// Depends on btpd_pkg.
module btpd_core
    import btpd_pkg::*;
#(
    parameter int PRESSES_NEEDED = PRESSES_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_pin_level,
    input  logic    i_clear_total,
    input  t_cfg    i_cfg,
    input  logic    i_enable_wr,
    output t_result o_result
);

    localparam logic [TALLY_W-1:0] NEED = TALLY_W'(PRESSES_NEEDED);

    logic                  r_prev_pin, n_prev_pin;
    logic                  r_db_busy, n_db_busy;
    logic [DEBOUNCE_W-1:0] r_db_left, n_db_left;
    logic                  r_win_busy, n_win_busy;
    logic [WINDOW_W-1:0]   r_win_left, n_win_left;
    logic [TALLY_W-1:0]    r_tally, n_tally;
    logic [SINCE_W-1:0]    r_since, n_since;
    logic [TOTAL_W-1:0]    r_total, n_total;
    logic                  triple;
    logic                  accepted;
    logic                  too_soon;

    always_comb begin
        n_prev_pin = i_pin_level;
        n_db_busy  = r_db_busy;
        n_db_left  = r_db_left;
        n_win_busy = r_win_busy;
        n_win_left = r_win_left;
        n_tally    = r_tally;
        n_since    = (r_since != '1) ? r_since + 1'b1 : r_since;
        n_total    = i_clear_total ? '0 : r_total;
        triple     = 1'b0;
        accepted   = 1'b0;
        too_soon   = 1'b0;

        if (r_win_busy) begin
            if (r_win_left != '0) begin
                n_win_left = r_win_left - 1'b1;
            end
            if (n_win_left == '0) begin
                n_win_busy = 1'b0;
                if (r_tally != '0 && r_tally < NEED) begin
                    n_tally = '0;
                end
            end
        end

        if (r_db_busy) begin
            if (r_db_left != '0) begin
                n_db_left = r_db_left - 1'b1;
            end
            if (n_db_left == '0) begin
                n_db_busy = 1'b0;
                if (!i_pin_level) begin
                    too_soon = (n_tally != '0) && (n_since < i_cfg.min_gap_ticks);
                    if (!too_soon) begin
                        accepted = 1'b1;
                        n_tally  = n_tally + 1'b1;
                        n_total  = n_total + 1'b1;
                        n_since  = '0;
                        if (n_tally == TALLY_W'(1)) begin
                            n_win_busy = 1'b1;
                            n_win_left = (i_cfg.window_ticks != '0) ?
                                         i_cfg.window_ticks : WINDOW_W'(1);
                        end
                        if (n_tally >= NEED) begin
                            triple     = 1'b1;
                            n_tally    = '0;
                            n_win_busy = 1'b0;
                            n_win_left = '0;
                        end
                    end
                end
            end
        end

        if (i_cfg.enable && !r_db_busy && r_prev_pin && !i_pin_level) begin
            n_db_busy = 1'b1;
            n_db_left = (i_cfg.debounce_ticks != '0) ?
                        i_cfg.debounce_ticks : DEBOUNCE_W'(1);
        end
    end

    always_comb begin
        o_result.triple_detected = triple;
        o_result.press_accepted  = accepted;
        o_result.pending_presses = (n_tally > TALLY_W'(3)) ? PENDING_W'(3) :
                                   n_tally[PENDING_W-1:0];
        o_result.total_presses   = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pin <= 1'b1;
            r_db_busy  <= 1'b0;
            r_db_left  <= '0;
            r_win_busy <= 1'b0;
            r_win_left <= '0;
            r_tally    <= '0;
            r_since    <= '0;
            r_total    <= '0;
        end else begin
            if (i_step) begin
                r_prev_pin <= n_prev_pin;
                r_db_busy  <= n_db_busy;
                r_db_left  <= n_db_left;
                r_win_busy <= n_win_busy;
                r_win_left <= n_win_left;
                r_since    <= n_since;
                r_total    <= n_total;
            end
            if (i_enable_wr) begin
                r_tally <= '0;
            end else if (i_step) begin
                r_tally <= n_tally;
            end
        end
    end

endmodule

// ----- sv/button_triple_press_detector.sv -----
// Top level of the button triple-press detector.
// Holds the configuration registers, the input register and the result register.
// Depends on btpd_pkg and btpd_core.

// Each input beat is one millisecond tick and yields exactly one result beat. The block takes
// one tick per clock cycle unless the output stalls; a tick's result passes through the input
// register and then the result register, the only stages, and the whole tick update lies
// between them. Configuration writes take effect at once and are meant for an idle block.
module button_triple_press_detector
    import btpd_pkg::*;
#(
    parameter int PRESSES_NEEDED = PRESSES_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_pin_level,
    input  logic                  i_clear_total,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_triple_detected,
    output logic                  o_press_accepted,
    output logic [PENDING_W-1:0]  o_pending_presses,
    output logic [TOTAL_W-1:0]    o_total_presses
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    logic    r_in_pin;
    logic    r_in_clear;
    logic    r_out_valid;
    t_result r_out;
    t_result step_result;
    logic    out_free;
    logic    step;
    logic    in_take;
    logic    enable_wr;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign enable_wr  = i_cfg_we && (i_cfg_idx == REG_ENABLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable         <= ENABLE_RST;
            r_cfg.debounce_ticks <= DEBOUNCE_RST;
            r_cfg.window_ticks   <= WINDOW_RST;
            r_cfg.min_gap_ticks  <= MIN_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ENABLE:   r_cfg.enable         <= i_cfg_data[0];
                REG_DEBOUNCE: r_cfg.debounce_ticks <= i_cfg_data[DEBOUNCE_W-1:0];
                REG_WINDOW:   r_cfg.window_ticks   <= i_cfg_data[WINDOW_W-1:0];
                REG_MIN_GAP:  r_cfg.min_gap_ticks  <= i_cfg_data[GAP_W-1:0];
                default:      r_cfg                <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pin   <= i_pin_level;
            r_in_clear <= i_clear_total;
        end
    end

    btpd_core #(
        .PRESSES_NEEDED(PRESSES_NEEDED)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_pin_level   (r_in_pin),
        .i_clear_total (r_in_clear),
        .i_cfg         (r_cfg),
        .i_enable_wr   (enable_wr),
        .o_result      (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_triple_detected = r_out.triple_detected;
    assign o_press_accepted  = r_out.press_accepted;
    assign o_pending_presses = r_out.pending_presses;
    assign o_total_presses   = r_out.total_presses;

    // A completed set is always reported together with the press that completed it.
    a_triple_has_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.triple_detected |-> r_out.press_accepted)
        else $error("triple reported without an accepted press");

    // A completed set leaves nothing pending.
    a_triple_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.triple_detected |-> r_out.pending_presses == '0)
        else $error("pending count not cleared by a triple");

    // The input side only stalls when a result is waiting and the consumer is stalling.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid && i_out_stall && r_in_valid)
        else $error("input stalled without a blocked result");

    // A tick that moves on leaves a result behind in the next cycle.
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("tick processed without a result");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for button_triple_press_detector.
// Plays a directed table of ticks and register writes, then random presses; predicts each result.
// Depends on btpd_pkg and the detector RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import btpd_pkg::*;

    localparam int PRESSES     = PRESSES_DEFAULT;
    localparam int TICK_TARGET = 1600;
    localparam int TAIL_TICKS  = 1030;
    localparam int STALL_LIMIT = 1000;
    localparam int MAX_PRINTS  = 100;

    typedef enum bit {ROW_TICK, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  pin;
        logic                  clr;
        logic                  typed;
        t_result               want;
    } t_plan_row;

    localparam t_result NOTHING = '0;

    localparam int PLAN_LEN = 40;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b1, 1'b1, 1'b1, NOTHING},
        '{ROW_REG,  REG_DEBOUNCE, 16'd1,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_REG,  REG_WINDOW,   16'd4,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_REG,  REG_MIN_GAP,  16'd1,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_REG,  REG_WINDOW,   16'd0,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_REG,  REG_WINDOW,   16'hFFFF,  1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_REG,  REG_MIN_GAP,  16'hFFFF,  1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_REG,  REG_MIN_GAP,  16'd0,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b1, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_REG,  REG_ENABLE,   16'd0,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_REG,  REG_ENABLE,   16'd1,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_REG,  REG_DEBOUNCE, 16'd0,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b1, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b0, 1'b0, 1'b0, NOTHING},
        '{ROW_TICK, REG_ENABLE,   16'd0,     1'b1, 1'b0, 1'b0, NOTHING}
    };

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = REG_ENABLE;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic                  i_pin_level   = 1'b1;
    logic                  i_clear_total = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic                  o_triple_detected;
    logic                  o_press_accepted;
    logic [PENDING_W-1:0]  o_pending_presses;
    logic [TOTAL_W-1:0]    o_total_presses;

    button_triple_press_detector #(
        .PRESSES_NEEDED(PRESSES)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_pin_level(i_pin_level),
        .i_clear_total(i_clear_total),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_triple_detected(o_triple_detected),
        .o_press_accepted(o_press_accepted),
        .o_pending_presses(o_pending_presses),
        .o_total_presses(o_total_presses)
    );

    // Detector model: configuration and tick state.
    logic                  m_enable   = ENABLE_RST;
    logic [DEBOUNCE_W-1:0] m_debounce = DEBOUNCE_RST;
    logic [WINDOW_W-1:0]   m_window   = WINDOW_RST;
    logic [GAP_W-1:0]      m_min_gap  = MIN_GAP_RST;
    logic                  btn_prev    = 1'b1;
    logic                  deb_running = 1'b0;
    logic [DEBOUNCE_W-1:0] deb_left    = '0;
    logic                  win_open    = 1'b0;
    logic [WINDOW_W-1:0]   win_left    = '0;
    logic [TALLY_W-1:0]    tally       = '0;
    logic [SINCE_W-1:0]    since_press = '0;
    logic [TOTAL_W-1:0]    lifetime    = '0;

    t_result due_results [$];
    int      mismatches  = 0;
    int      results_seen = 0;
    int      ticks_sent  = 0;
    int      quiet_cycles = 0;
    bit      steady      = 1'b0;

    always #5 i_clk = ~i_clk;

    function automatic t_result step_detector(input logic pin, input logic clr);
        t_result r;
        logic    deb_was;
        r = '0;
        deb_was = deb_running;
        if (since_press != {SINCE_W{1'b1}}) since_press = since_press + 1'b1;
        if (clr) lifetime = '0;
        if (win_open) begin
            if (win_left != 0) win_left = win_left - 1'b1;
            if (win_left == 0) begin
                win_open = 1'b0;
                if (tally > 0 && tally < PRESSES) tally = '0;
            end
        end
        if (deb_running) begin
            if (deb_left != 0) deb_left = deb_left - 1'b1;
            if (deb_left == 0) begin
                deb_running = 1'b0;
                if (!pin && !(tally != 0 && since_press < m_min_gap)) begin
                    r.press_accepted = 1'b1;
                    tally = tally + 1'b1;
                    lifetime = lifetime + 1'b1;
                    since_press = '0;
                    if (tally == 1) begin
                        win_open = 1'b1;
                        win_left = (m_window != 0) ? m_window : WINDOW_W'(1);
                    end
                    if (tally >= PRESSES) begin
                        r.triple_detected = 1'b1;
                        tally = '0;
                        win_open = 1'b0;
                        win_left = '0;
                    end
                end
            end
        end
        if (m_enable && !deb_was && btn_prev && !pin) begin
            deb_running = 1'b1;
            deb_left = (m_debounce != 0) ? m_debounce : DEBOUNCE_W'(1);
        end
        btn_prev = pin;
        r.pending_presses = (tally > 3) ? PENDING_W'(3) : tally[PENDING_W-1:0];
        r.total_presses = lifetime;
        return r;
    endfunction

    task automatic report(input string msg);
        if (mismatches < MAX_PRINTS) $display("tb: %s", msg);
        mismatches++;
    endtask

    task automatic send_tick(input logic pin, input logic clr, input logic typed,
                             input t_result want);
        t_result predicted;
        if (!steady) begin
            while ($urandom_range(99) < 38) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid    <= 1'b1;
        i_pin_level   <= pin;
        i_clear_total <= clr;
        do @(posedge i_clk); while (o_in_stall);
        predicted = step_detector(pin, clr);
        due_results.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    task automatic hold_pin(input logic pin, input int n);
        repeat (n) send_tick(pin, $urandom_range(49) == 0, 1'b0, NOTHING);
    endtask

    // Registers change only once every result beat in flight has come back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ENABLE: begin
                m_enable = data[0];
                tally = '0;
            end
            REG_DEBOUNCE: m_debounce = data[DEBOUNCE_W-1:0];
            REG_WINDOW:   m_window = data[WINDOW_W-1:0];
            REG_MIN_GAP:  m_min_gap = data[GAP_W-1:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= steady ? 1'b0 : ($urandom_range(99) < 38);
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                report($sformatf("result beat %0d arrived with nothing expected", results_seen));
            end else begin
                want = due_results.pop_front();
                if (o_triple_detected !== want.triple_detected)
                    report($sformatf("beat %0d triple_detected got %b want %b", results_seen,
                                     o_triple_detected, want.triple_detected));
                if (o_press_accepted !== want.press_accepted)
                    report($sformatf("beat %0d press_accepted got %b want %b", results_seen,
                                     o_press_accepted, want.press_accepted));
                if (o_pending_presses !== want.pending_presses)
                    report($sformatf("beat %0d pending_presses got %0d want %0d", results_seen,
                                     o_pending_presses, want.pending_presses));
                if (o_total_presses !== want.total_presses)
                    report($sformatf("beat %0d total_presses got %0d want %0d", results_seen,
                                     o_total_presses, want.total_presses));
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int deb;
        int win;
        int gap;
        int kind;
        int phase;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < PLAN_LEN; r++) begin
            if (PLAN[r].kind == ROW_REG)
                write_reg(PLAN[r].idx, PLAN[r].data);
            else
                send_tick(PLAN[r].pin, PLAN[r].clr, PLAN[r].typed, PLAN[r].want);
        end

        phase = 0;
        while (ticks_sent < TICK_TARGET - TAIL_TICKS) begin
            steady = (phase == 1 || phase == 2);
            deb = ($urandom_range(7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            case ($urandom_range(7))
                0:       win = $urandom_range(0, 5);
                1:       win = 65535;
                default: win = $urandom_range(10, 120);
            endcase
            case ($urandom_range(7))
                0:       gap = $urandom_range(21, 60);
                1:       gap = 65535;
                default: gap = $urandom_range(0, 20);
            endcase
            write_reg(REG_DEBOUNCE, CFG_DATA_W'(deb));
            write_reg(REG_WINDOW, CFG_DATA_W'(win));
            write_reg(REG_MIN_GAP, CFG_DATA_W'(gap));
            write_reg(REG_ENABLE, CFG_DATA_W'($urandom_range(7) != 0));
            repeat ($urandom_range(8, 20)) begin
                kind = $urandom_range(9);
                if (kind <= 6) begin
                    hold_pin(1'b0, deb + $urandom_range(1, 4));
                    hold_pin(1'b1, $urandom_range(1, 12));
                end else if (kind == 7) begin
                    hold_pin(1'b0, $urandom_range(1, deb + 1));
                    hold_pin(1'b1, $urandom_range(1, 3));
                end else if (kind == 8) begin
                    repeat ($urandom_range(1, 10)) hold_pin(1'($urandom_range(1)), 1);
                end else begin
                    hold_pin(1'b1, $urandom_range(1, (win > 300) ? 300 : win + 5));
                end
            end
            phase++;
        end

        steady = 1'b0;
        write_reg(REG_DEBOUNCE, CFG_DATA_W'(1023));
        write_reg(REG_WINDOW, 16'hFFFF);
        write_reg(REG_MIN_GAP, CFG_DATA_W'(1));
        write_reg(REG_ENABLE, CFG_DATA_W'(1));
        hold_pin(1'b1, 2);
        hold_pin(1'b0, 1025);
        hold_pin(1'b1, 3);

        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/btpd_pkg.sv
sv/btpd_core.sv
sv/button_triple_press_detector.sv
sim/tb.sv
